[hw/rtl/inline_color_code_decoder_unit_defines.svh]
// Assertion macros shared by the decoder RTL.
`ifndef INLINE_COLOR_CODE_DECODER_UNIT_DEFINES_SVH
`define INLINE_COLOR_CODE_DECODER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define ICCD_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ICCD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ICCD_ASSERT_SAME(lbl, ante, cons)
`define ICCD_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

[hw/rtl/iccd_pkg.sv]
package iccd_pkg;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int MAX_CHARS = 4;

  typedef enum logic [6:0] {
    PH_IDLE  = 7'b0000001,
    PH_AMP   = 7'b0000010,
    PH_PLUS  = 7'b0000100,
    PH_MINUS = 7'b0001000,
    PH_EQ1   = 7'b0010000,
    PH_EQ2   = 7'b0100000,
    PH_SKIP  = 7'b1000000
  } phase_t;

  typedef enum logic {
    REG_SHOW_CODES      = 1'b0,
    REG_INTERPRET_CODES = 1'b1
  } reg_idx_t;

  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_N_LO  = 8'h6E;
  localparam logic [7:0] CH_N_UP  = 8'h4E;

  localparam logic [4:0] FG_RESET = 5'd7;
  localparam logic [2:0] BG_RESET = 3'd0;
  localparam logic [3:0] LETTER_NONE = 4'd8;

  typedef struct packed {
    logic [MAX_CHARS-1:0][7:0] chars;
    logic [2:0]                count;
    logic [4:0]                fg;
    logic [2:0]                bg;
  } bundle_t;

  function automatic logic is_upper(input logic [7:0] c);
    return (c >= 8'h41) && (c <= 8'h5A);
  endfunction

  function automatic logic [7:0] to_upper(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) ? c - 8'd32 : c;
  endfunction

  function automatic logic [3:0] letter_index(input logic [7:0] c);
    logic [3:0] k;
    case (to_upper(c))
      8'h4C: k = 4'd0;
      8'h42: k = 4'd1;
      8'h47: k = 4'd2;
      8'h43: k = 4'd3;
      8'h52: k = 4'd4;
      8'h4D: k = 4'd5;
      8'h59: k = 4'd6;
      8'h57: k = 4'd7;
      default: k = LETTER_NONE;
    endcase
    return k;
  endfunction

  // Bit 4 set means the byte is not a color letter.
  function automatic logic [4:0] fg_value(input logic [7:0] c);
    logic [3:0] k;
    k = letter_index(c);
    if (k[3]) begin
      return 5'd16;
    end
    return {1'b0, is_upper(c), k[2:0]};
  endfunction

endpackage

[hw/rtl/iccd_text_if.sv]
interface iccd_text_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       end_of_string;

  modport source (output valid, output char_in, output end_of_string, input ready);
  modport sink (input valid, input char_in, input end_of_string, output ready);
endinterface

[hw/rtl/iccd_glyph_if.sv]
interface iccd_glyph_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic [4:0] out_fg;
  logic [2:0] out_bg;
  logic       last_of_run;

  modport source (output valid, output out_char, output out_fg, output out_bg,
                  output last_of_run, input ready);
  modport sink (input valid, input out_char, input out_fg, input out_bg,
                input last_of_run, output ready);
endinterface

[hw/rtl/iccd_cfg_if.sv]
interface iccd_cfg_if;
  logic valid;
  logic ready;
  logic idx;
  logic data;

  modport source (output valid, output idx, output data, input ready);
  modport sink (input valid, input idx, input data, output ready);
endinterface

[hw/rtl/inline_color_code_decoder_unit.sv]
// Decodes a text byte stream with inline color codes into displayed characters, each tagged
// with its foreground and background color. A byte is taken on every clock cycle as long as the
// four-entry run queue between the parser and the output serializer has room; a byte yields
// zero to four characters, which the serializer's single output register sends one at a time.
// Sustained throughput is one byte per cycle when bytes produce at most one character each,
// and one character per cycle otherwise, in both cases while the output is ready. A character
// reaches the output through a queue slot and then the output register. Configuration writes are
// always ready and should be issued only while no transaction is in flight.
module inline_color_code_decoder_unit (
  input  logic         clk,
  input  logic         rst,
  iccd_text_if.sink    text,
  iccd_glyph_if.source glyph,
  iccd_cfg_if.sink     cfg
);
  import iccd_pkg::*;

  logic    push;
  logic    full;
  logic    head_valid;
  logic    pop;
  bundle_t push_data;
  bundle_t head;

  iccd_front u_front (
    .clk    (clk),
    .rst    (rst),
    .text   (text),
    .cfg    (cfg),
    .full   (full),
    .push   (push),
    .bundle (push_data)
  );

  iccd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_data),
    .full       (full),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  iccd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .glyph      (glyph)
  );

endmodule

[hw/rtl/iccd_front.sv]
module iccd_front (
  input  logic             clk,
  input  logic             rst,
  iccd_text_if.sink        text,
  iccd_cfg_if.sink         cfg,
  input  logic             full,
  output logic             push,
  output iccd_pkg::bundle_t bundle
);
  import iccd_pkg::*;

  `include "inline_color_code_decoder_unit_defines.svh"

  phase_t     phase, phase_next;
  logic [4:0] fg_color, fg_next;
  logic [2:0] bg_color, bg_next;
  logic       bold_flag, bold_next;
  logic [7:0] held_letter, held_next;
  logic       show_codes;
  logic       interpret_codes;

  logic [MAX_CHARS-1:0][7:0] em;
  logic [2:0]                n;
  logic [7:0]                c;
  logic [4:0]                v;
  logic [3:0]                k;
  logic [3:0]                hk;
  logic                      accept;

  assign c = text.char_in;
  assign text.ready = !full;
  assign cfg.ready = 1'b1;
  assign accept = text.valid && !full;

  // Every character of one transaction carries the colors held before it.
  always_comb begin
    phase_next = phase;
    fg_next = fg_color;
    bg_next = bg_color;
    bold_next = bold_flag;
    held_next = held_letter;
    em = '0;
    n = 3'd0;
    v = fg_value(bold_flag ? to_upper(c) : c);
    k = letter_index(c);
    hk = letter_index(held_letter);
    case (phase)
      PH_AMP: begin
        if (c == CH_N_LO || c == CH_N_UP) begin
          if (show_codes) begin
            em[n[1:0]] = CH_AMP; n = n + 3'd1;
            em[n[1:0]] = c;      n = n + 3'd1;
          end
          if (interpret_codes) begin
            fg_next = FG_RESET;
            bg_next = BG_RESET;
          end
          bold_next = 1'b0;
          phase_next = PH_IDLE;
        end else if (c == CH_PLUS) begin
          phase_next = PH_PLUS;
        end else if (c == CH_MINUS) begin
          phase_next = PH_MINUS;
        end else if (c == CH_EQ) begin
          phase_next = PH_EQ1;
        end else begin
          em[n[1:0]] = CH_AMP; n = n + 3'd1;
          if (c == CH_AMP) begin
            phase_next = PH_AMP;
          end else begin
            em[n[1:0]] = c; n = n + 3'd1;
            phase_next = PH_IDLE;
          end
        end
      end
      PH_PLUS: begin
        if (!v[4]) begin
          if (show_codes) begin
            em[n[1:0]] = CH_AMP;  n = n + 3'd1;
            em[n[1:0]] = CH_PLUS; n = n + 3'd1;
            em[n[1:0]] = c;       n = n + 3'd1;
          end
          if (interpret_codes) begin
            fg_next = v;
          end
          if (is_upper(c)) begin
            bold_next = 1'b1;
          end
        end else begin
          em[n[1:0]] = CH_AMP;  n = n + 3'd1;
          em[n[1:0]] = CH_PLUS; n = n + 3'd1;
          em[n[1:0]] = c;       n = n + 3'd1;
        end
        phase_next = PH_IDLE;
      end
      PH_MINUS: begin
        if (!k[3]) begin
          if (show_codes) begin
            em[n[1:0]] = CH_AMP;   n = n + 3'd1;
            em[n[1:0]] = CH_MINUS; n = n + 3'd1;
            em[n[1:0]] = c;        n = n + 3'd1;
          end
          if (interpret_codes) begin
            bg_next = k[2:0];
            if (is_upper(c)) begin
              fg_next = {2'b10, k[2:0]};
            end
          end
        end else begin
          em[n[1:0]] = CH_AMP;   n = n + 3'd1;
          em[n[1:0]] = CH_MINUS; n = n + 3'd1;
          em[n[1:0]] = c;        n = n + 3'd1;
        end
        phase_next = PH_IDLE;
      end
      PH_EQ1: begin
        if (!k[3]) begin
          held_next = c;
          phase_next = PH_EQ2;
        end else begin
          em[n[1:0]] = CH_AMP; n = n + 3'd1;
          em[n[1:0]] = CH_EQ;  n = n + 3'd1;
          em[n[1:0]] = c;      n = n + 3'd1;
          phase_next = PH_SKIP;
        end
      end
      PH_EQ2: begin
        v = fg_value(c);
        if (!v[4]) begin
          if (show_codes) begin
            em[n[1:0]] = CH_AMP;      n = n + 3'd1;
            em[n[1:0]] = CH_EQ;       n = n + 3'd1;
            em[n[1:0]] = held_letter; n = n + 3'd1;
            em[n[1:0]] = c;           n = n + 3'd1;
          end
          if (interpret_codes) begin
            bg_next = hk[2:0];
            fg_next = v;
          end
        end else begin
          em[n[1:0]] = CH_AMP;      n = n + 3'd1;
          em[n[1:0]] = CH_EQ;       n = n + 3'd1;
          em[n[1:0]] = held_letter; n = n + 3'd1;
          em[n[1:0]] = c;           n = n + 3'd1;
        end
        phase_next = PH_IDLE;
      end
      PH_SKIP: begin
        em[n[1:0]] = c; n = n + 3'd1;
        phase_next = PH_IDLE;
      end
      default: begin
        if (c == CH_AMP) begin
          phase_next = PH_AMP;
        end else begin
          em[n[1:0]] = c; n = n + 3'd1;
        end
      end
    endcase

    // A code cut off by the end of the string comes out as plain text.
    if (text.end_of_string) begin
      case (phase_next)
        PH_AMP: begin
          em[n[1:0]] = CH_AMP; n = n + 3'd1;
        end
        PH_PLUS: begin
          em[n[1:0]] = CH_AMP;  n = n + 3'd1;
          em[n[1:0]] = CH_PLUS; n = n + 3'd1;
        end
        PH_MINUS: begin
          em[n[1:0]] = CH_AMP;   n = n + 3'd1;
          em[n[1:0]] = CH_MINUS; n = n + 3'd1;
        end
        PH_EQ1: begin
          em[n[1:0]] = CH_AMP; n = n + 3'd1;
          em[n[1:0]] = CH_EQ;  n = n + 3'd1;
        end
        PH_EQ2: begin
          em[n[1:0]] = CH_AMP;    n = n + 3'd1;
          em[n[1:0]] = CH_EQ;     n = n + 3'd1;
          em[n[1:0]] = held_next; n = n + 3'd1;
        end
        default: begin
        end
      endcase
      phase_next = PH_IDLE;
    end
  end

  assign push = accept && (n != 3'd0);
  assign bundle.chars = em;
  assign bundle.count = n;
  assign bundle.fg = fg_color;
  assign bundle.bg = bg_color;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      fg_color <= FG_RESET;
      bg_color <= BG_RESET;
      bold_flag <= 1'b0;
      held_letter <= 8'd0;
    end else if (accept) begin
      phase <= phase_next;
      fg_color <= fg_next;
      bg_color <= bg_next;
      bold_flag <= bold_next;
      held_letter <= held_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      show_codes <= 1'b0;
      interpret_codes <= 1'b1;
    end else if (cfg.valid) begin
      case (cfg.idx)
        REG_SHOW_CODES:      show_codes <= cfg.data;
        REG_INTERPRET_CODES: interpret_codes <= cfg.data;
        default: begin
        end
      endcase
    end
  end

  `ICCD_ASSERT_SAME(a_bundle_size, push, bundle.count <= 3'(MAX_CHARS))
  `ICCD_ASSERT_NEXT(a_eos_idle, accept && text.end_of_string, phase == PH_IDLE)

endmodule

[hw/rtl/iccd_queue.sv]
module iccd_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  iccd_pkg::bundle_t push_data,
  output logic              full,
  output logic              head_valid,
  output iccd_pkg::bundle_t head,
  input  logic              pop
);
  import iccd_pkg::*;

  `include "inline_color_code_decoder_unit_defines.svh"

  bundle_t             slots [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QPTR_W:0]     count;

  assign full = (count == (QPTR_W+1)'(QDEPTH));
  assign head_valid = (count != '0);
  assign head = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  `ICCD_ASSERT_SAME(a_no_overflow, push, !full)
  `ICCD_ASSERT_SAME(a_no_underflow, pop, head_valid)

endmodule

[hw/rtl/iccd_back.sv]
module iccd_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              head_valid,
  input  iccd_pkg::bundle_t head,
  output logic              pop,
  iccd_glyph_if.source      glyph
);
  import iccd_pkg::*;

  `include "inline_color_code_decoder_unit_defines.svh"

  logic       out_valid;
  logic [7:0] out_char;
  logic [4:0] out_fg;
  logic [2:0] out_bg;
  logic       out_last;
  logic [1:0] pos;
  logic       load;
  logic       last;

  assign load = head_valid && (!out_valid || glyph.ready);
  assign last = (({1'b0, pos} + 3'd1) == head.count);
  assign pop = load && last;

  assign glyph.valid = out_valid;
  assign glyph.out_char = out_char;
  assign glyph.out_fg = out_fg;
  assign glyph.out_bg = out_bg;
  assign glyph.last_of_run = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pos <= 2'd0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        pos <= last ? 2'd0 : pos + 2'd1;
      end else if (glyph.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_char <= head.chars[pos];
      out_fg <= head.fg;
      out_bg <= head.bg;
      out_last <= last;
    end
  end

  `ICCD_ASSERT_SAME(a_pos_in_run, head_valid, {1'b0, pos} < head.count)

endmodule

[bench/inline_color_code_decoder_unit_tb.sv]
module inline_color_code_decoder_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import iccd_pkg::*;

  localparam int CYCLE_LIMIT = 100000;
  localparam int DRAIN_CYCLES = 12;
  localparam logic [0:7][7:0] PALETTE = "LBGCRMYW";

  typedef struct packed {
    logic [7:0] ch;
    logic [4:0] fg;
    logic [2:0] bg;
    logic       last;
  } glyph_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic calm = 1'b0;
  int errors = 0;
  int cycles = 0;
  int bytes_sent = 0;

  iccd_text_if  text_ch();
  iccd_glyph_if glyph_ch();
  iccd_cfg_if   cfg_ch();

  inline_color_code_decoder_unit dut (
    .clk   (clk),
    .rst   (rst),
    .text  (text_ch),
    .glyph (glyph_ch),
    .cfg   (cfg_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Decoder state as the display would track it.
  glyph_t     glyphs_due[$];
  phase_t     scan_phase = PH_IDLE;
  logic [4:0] cur_fg = 5'd7;
  logic [2:0] cur_bg = 3'd0;
  logic       bold = 1'b0;
  logic [7:0] bg_letter = 8'd0;
  logic       echo_on = 1'b0;
  logic       apply_on = 1'b1;
  int         run_len;

  function automatic logic is_cap(input logic [7:0] c);
    return c >= "A" && c <= "Z";
  endfunction

  function automatic logic [7:0] upcase(input logic [7:0] c);
    return (c >= "a" && c <= "z") ? c - 8'd32 : c;
  endfunction

  function automatic logic [3:0] color_slot(input logic [7:0] c);
    for (int i = 0; i < 8; i++) begin
      if (upcase(c) == PALETTE[i]) begin
        return 4'(i);
      end
    end
    return LETTER_NONE;
  endfunction

  function automatic logic [4:0] fore_code(input logic [7:0] c);
    logic [3:0] k;
    k = color_slot(c);
    if (k[3]) begin
      return 5'd16;
    end
    return {1'b0, is_cap(c), k[2:0]};
  endfunction

  function automatic void put_glyph(input logic [7:0] c);
    glyph_t g;
    if (run_len < MAX_CHARS) begin
      g = '{ch: c, fg: cur_fg, bg: cur_bg, last: 1'b0};
      glyphs_due.push_back(g);
      run_len++;
    end
  endfunction

  function automatic void predict_byte(input logic [7:0] c, input logic eos);
    logic [4:0] v;
    logic [3:0] k;
    glyph_t g;
    run_len = 0;
    case (scan_phase)
      PH_AMP: begin
        if (c == CH_N_LO || c == CH_N_UP) begin
          if (echo_on) begin
            put_glyph(CH_AMP);
            put_glyph(c);
          end
          if (apply_on) begin
            cur_fg = FG_RESET;
            cur_bg = BG_RESET;
          end
          bold = 1'b0;
          scan_phase = PH_IDLE;
        end else if (c == CH_PLUS) begin
          scan_phase = PH_PLUS;
        end else if (c == CH_MINUS) begin
          scan_phase = PH_MINUS;
        end else if (c == CH_EQ) begin
          scan_phase = PH_EQ1;
        end else begin
          put_glyph(CH_AMP);
          if (c == CH_AMP) begin
            scan_phase = PH_AMP;
          end else begin
            put_glyph(c);
            scan_phase = PH_IDLE;
          end
        end
      end
      PH_PLUS: begin
        v = fore_code(bold ? upcase(c) : c);
        if (!v[4]) begin
          if (echo_on) begin
            put_glyph(CH_AMP);
            put_glyph(CH_PLUS);
            put_glyph(c);
          end
          if (apply_on) begin
            cur_fg = v;
          end
          if (is_cap(c)) begin
            bold = 1'b1;
          end
        end else begin
          put_glyph(CH_AMP);
          put_glyph(CH_PLUS);
          put_glyph(c);
        end
        scan_phase = PH_IDLE;
      end
      PH_MINUS: begin
        k = color_slot(c);
        if (!k[3]) begin
          if (echo_on) begin
            put_glyph(CH_AMP);
            put_glyph(CH_MINUS);
            put_glyph(c);
          end
          if (apply_on) begin
            cur_bg = k[2:0];
            if (is_cap(c)) begin
              cur_fg = {2'b10, k[2:0]};
            end
          end
        end else begin
          put_glyph(CH_AMP);
          put_glyph(CH_MINUS);
          put_glyph(c);
        end
        scan_phase = PH_IDLE;
      end
      PH_EQ1: begin
        k = color_slot(c);
        if (!k[3]) begin
          bg_letter = c;
          scan_phase = PH_EQ2;
        end else begin
          put_glyph(CH_AMP);
          put_glyph(CH_EQ);
          put_glyph(c);
          scan_phase = PH_SKIP;
        end
      end
      PH_EQ2: begin
        v = fore_code(c);
        if (!v[4]) begin
          if (echo_on) begin
            put_glyph(CH_AMP);
            put_glyph(CH_EQ);
            put_glyph(bg_letter);
            put_glyph(c);
          end
          if (apply_on) begin
            k = color_slot(bg_letter);
            cur_bg = k[2:0];
            cur_fg = v;
          end
        end else begin
          put_glyph(CH_AMP);
          put_glyph(CH_EQ);
          put_glyph(bg_letter);
          put_glyph(c);
        end
        scan_phase = PH_IDLE;
      end
      PH_SKIP: begin
        put_glyph(c);
        scan_phase = PH_IDLE;
      end
      default: begin
        if (c == CH_AMP) begin
          scan_phase = PH_AMP;
        end else begin
          put_glyph(c);
        end
      end
    endcase
    if (eos) begin
      case (scan_phase)
        PH_AMP: put_glyph(CH_AMP);
        PH_PLUS: begin
          put_glyph(CH_AMP);
          put_glyph(CH_PLUS);
        end
        PH_MINUS: begin
          put_glyph(CH_AMP);
          put_glyph(CH_MINUS);
        end
        PH_EQ1: begin
          put_glyph(CH_AMP);
          put_glyph(CH_EQ);
        end
        PH_EQ2: begin
          put_glyph(CH_AMP);
          put_glyph(CH_EQ);
          put_glyph(bg_letter);
        end
        default: begin
        end
      endcase
      scan_phase = PH_IDLE;
    end
    if (run_len > 0) begin
      g = glyphs_due.pop_back();
      g.last = 1'b1;
      glyphs_due.push_back(g);
    end
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at cycle %0d: %s", cycles, msg);
    errors++;
  endtask

  task automatic check_glyph();
    glyph_t want;
    if (glyphs_due.size() == 0) begin
      report_mismatch($sformatf("unexpected character 0x%02h", glyph_ch.out_char));
    end else begin
      want = glyphs_due.pop_front();
      if (glyph_ch.out_char !== want.ch) begin
        report_mismatch($sformatf("out_char 0x%02h, wanted 0x%02h", glyph_ch.out_char, want.ch));
      end
      if (glyph_ch.out_fg !== want.fg) begin
        report_mismatch($sformatf("out_fg %0d, wanted %0d (char 0x%02h)",
                                  glyph_ch.out_fg, want.fg, want.ch));
      end
      if (glyph_ch.out_bg !== want.bg) begin
        report_mismatch($sformatf("out_bg %0d, wanted %0d (char 0x%02h)",
                                  glyph_ch.out_bg, want.bg, want.ch));
      end
      if (glyph_ch.last_of_run !== want.last) begin
        report_mismatch($sformatf("last_of_run %0b, wanted %0b (char 0x%02h)",
                                  glyph_ch.last_of_run, want.last, want.ch));
      end
    end
  endtask

  always @(posedge clk) begin
    glyph_ch.ready <= calm || ($urandom_range(99) >= 16);
    if (!rst && glyph_ch.valid && glyph_ch.ready) begin
      check_glyph();
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] c, input logic eos);
    while (!calm && $urandom_range(99) < 16) begin
      text_ch.valid <= 1'b0;
      @(posedge clk);
    end
    text_ch.valid <= 1'b1;
    text_ch.char_in <= c;
    text_ch.end_of_string <= eos;
    do @(posedge clk); while (!text_ch.ready);
    predict_byte(c, eos);
    bytes_sent++;
  endtask

  task automatic send_text(input string s, input logic eos);
    for (int i = 0; i < s.len(); i++) begin
      send_byte(s[i], eos && (i == s.len() - 1));
    end
  endtask

  // Waits until every expected character is out and the parser has gone quiet.
  task automatic drain_idle();
    text_ch.valid <= 1'b0;
    while (glyphs_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t r, input logic val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.idx <= r;
    cfg_ch.data <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    if (r == REG_SHOW_CODES) begin
      echo_on = val;
    end else begin
      apply_on = val;
    end
  endtask

  function automatic logic [7:0] pick_letter();
    return PALETTE[$urandom_range(7)] | ($urandom_range(1) ? 8'h20 : 8'h00);
  endfunction

  function automatic logic [7:0] pick_op();
    case ($urandom_range(2))
      0: return CH_PLUS;
      1: return CH_MINUS;
      default: return CH_EQ;
    endcase
  endfunction

  function automatic logic [7:0] pick_special();
    case ($urandom_range(5))
      0: return CH_AMP;
      1: return pick_op();
      2: return CH_N_LO;
      3: return CH_N_UP;
      default: return pick_letter();
    endcase
  endfunction

  // Well-formed codes with random letters in nine of twenty token kinds, the rest text and broken codes.
  task automatic send_random_token();
    logic [7:0] seq[$];
    int kind;
    kind = $urandom_range(19);
    if (kind <= 5) begin
      seq = '{8'($urandom_range(255))};
    end else if (kind <= 7) begin
      seq = '{CH_AMP, ($urandom_range(1) ? CH_N_UP : CH_N_LO)};
    end else if (kind <= 10) begin
      seq = '{CH_AMP, CH_PLUS, pick_letter()};
    end else if (kind <= 12) begin
      seq = '{CH_AMP, CH_MINUS, pick_letter()};
    end else if (kind <= 14) begin
      seq = '{CH_AMP, CH_EQ, pick_letter(), pick_letter()};
    end else if (kind <= 16) begin
      seq = '{CH_AMP, pick_op(), 8'($urandom_range(255)), 8'($urandom_range(255))};
    end else if (kind == 17) begin
      seq = '{CH_AMP, 8'($urandom_range(255))};
    end else begin
      seq = '{pick_special()};
    end
    foreach (seq[i]) begin
      send_byte(seq[i], $urandom_range(11) == 0);
    end
  endtask

  task automatic run_random(input int n);
    int stop_at;
    stop_at = bytes_sent + n;
    while (bytes_sent < stop_at) begin
      send_random_token();
    end
  endtask

  task automatic test_literal_and_codes();
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_text("&+R&+gx", 1'b0);
    send_text("&-Bx", 1'b0);
    send_text("&=bWx", 1'b1);
    send_text("&&q&+?", 1'b0);
    send_text("&=qz&=bq", 1'b0);
    send_text("&n", 1'b0);
    send_text("&-", 1'b1);
    send_text("&=b", 1'b1);
    drain_idle();
  endtask

  task automatic test_code_echo();
    write_reg(REG_SHOW_CODES, 1'b1);
    send_text("&N&=Bw&+c&n", 1'b1);
    run_random(30);
    drain_idle();
  endtask

  task automatic test_colors_frozen();
    write_reg(REG_INTERPRET_CODES, 1'b0);
    run_random(25);
    drain_idle();
    write_reg(REG_SHOW_CODES, 1'b0);
    run_random(25);
    drain_idle();
  endtask

  task automatic test_back_to_back();
    write_reg(REG_INTERPRET_CODES, 1'b1);
    calm = 1'b1;
    run_random(40);
    calm = 1'b0;
    drain_idle();
  endtask

  task automatic test_full_echo_mix();
    write_reg(REG_SHOW_CODES, 1'b1);
    run_random(25);
    drain_idle();
  endtask

  initial begin
    text_ch.valid <= 1'b0;
    text_ch.char_in <= 8'h00;
    text_ch.end_of_string <= 1'b0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.idx <= REG_SHOW_CODES;
    cfg_ch.data <= 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_literal_and_codes();
    test_code_echo();
    test_colors_frozen();
    test_back_to_back();
    test_full_echo_mix();
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/iccd_pkg.sv
hw/rtl/iccd_text_if.sv
hw/rtl/iccd_glyph_if.sv
hw/rtl/iccd_cfg_if.sv
hw/rtl/iccd_front.sv
hw/rtl/iccd_queue.sv
hw/rtl/iccd_back.sv
hw/rtl/inline_color_code_decoder_unit.sv
bench/inline_color_code_decoder_unit_tb.sv
